@@ rtl/frm_pkg.sv @@
// types and codes shared by the recursive mutex lock manager
`timescale 1ns / 1ps

package frm_pkg;

  localparam int ID_W   = 4;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 3;

  // request commands
  localparam logic [CMD_W-1:0] CMD_LOCK   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TRY    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNLOCK = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
  localparam logic [STAT_W-1:0] STAT_QUEUED    = 3'd1;
  localparam logic [STAT_W-1:0] STAT_REFUSED   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_NOT_OWNER = 3'd3;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW  = 3'd4;

  // request item
  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [ID_W-1:0]  thread_id;
  } in_t;

  // result item
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic              wake_valid;
    logic [ID_W-1:0]   wake_thread;
  } out_t;

  // wait queue control
  typedef struct packed {
    logic            push;
    logic            pop;
    logic [ID_W-1:0] data;
  } q_cmd_t;

  // wait queue status
  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  // sequencer states
  typedef enum logic {
    S_IDLE,
    S_EXEC
  } ctl_state_t;

endpackage

@@ rtl/frm_queue.sv @@
// fifo wait queue of thread ids held in a synchronous memory
`timescale 1ns / 1ps

module frm_queue #(
  parameter int THREADS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    rd_en,
  input  frm_pkg::q_cmd_t         qcmd,
  output frm_pkg::q_stat_t        qstat,
  output logic [frm_pkg::ID_W-1:0] front
);

  localparam int PW = (THREADS > 1) ? $clog2(THREADS) : 1;
  localparam int CW = $clog2(THREADS + 1);

  logic [frm_pkg::ID_W-1:0] mem [THREADS];
  logic [frm_pkg::ID_W-1:0] front_r;
  logic [PW-1:0] head_r, head_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // memory: write at tail, registered read of head
  always_ff @(posedge clk) begin
    if (qcmd.push) begin
      mem[tail_r] <= qcmd.data;
    end
    if (rd_en) begin
      front_r <= mem[head_r];
    end
  end

  // pointer and fill count update with wrap at depth
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (qcmd.pop) begin
      head_nxt = (head_r == PW'(THREADS - 1)) ? '0 : head_r + PW'(1);
    end
    if (qcmd.push) begin
      tail_nxt = (tail_r == PW'(THREADS - 1)) ? '0 : tail_r + PW'(1);
    end
    if (qcmd.push && !qcmd.pop) begin
      count_nxt = count_r + CW'(1);
    end else if (qcmd.pop && !qcmd.push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  assign qstat.empty = (count_r == '0);
  assign qstat.full  = (count_r == CW'(THREADS));
  assign front       = front_r;

endmodule

@@ rtl/fifo_recursive_mutex.sv @@
// lock manager for one recursive mutex with a fifo wait queue
//
//   channel | ports                      | handshake
//   --------+----------------------------+------------------------------
//   request | start, busy, in_item       | taken when start && !busy
//   result  | out_valid, out_item        | one-cycle strobe, no stall
//
// Each item has an accept cycle, which reads the queue front from the wait
// queue memory, whose registered read holds off the decision, and then the
// next cycle (busy high), which decides and updates the state. The result is
// shown the cycle after that, overlapping the next accept. Reset is
// synchronous and empties the queue, frees the mutex and clears all
// waiting bits; no clearing pass is needed. Results cannot be held off.
`timescale 1ns / 1ps

module fifo_recursive_mutex #(
  parameter int THREADS    = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  frm_pkg::in_t in_item,
  output logic         out_valid,
  output frm_pkg::out_t out_item
);

  localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;

  frm_pkg::ctl_state_t state_r, state_nxt;
  logic [frm_pkg::CMD_W-1:0] cmd_r;
  logic [frm_pkg::ID_W-1:0]  id_r;
  logic                      owner_valid_r, owner_valid_nxt;
  logic [frm_pkg::ID_W-1:0]  owner_r, owner_nxt;
  logic [COUNT_BITS-1:0]     hold_r, hold_nxt;
  logic [THREADS-1:0]        mask_r, mask_nxt;
  logic                      out_valid_r, out_valid_nxt;
  frm_pkg::out_t             out_item_r, out_item_nxt;

  logic                      accept;
  frm_pkg::q_cmd_t           qcmd;
  frm_pkg::q_stat_t          qstat;
  logic [frm_pkg::ID_W-1:0]  front;

  logic                      is_owner;
  logic                      head_match;
  logic                      id_ok;
  logic [TW-1:0]             midx;

  assign busy   = (state_r == frm_pkg::S_EXEC);
  assign accept = start && !busy;

  frm_queue #(
    .THREADS(THREADS)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .rd_en(accept),
    .qcmd (qcmd),
    .qstat(qstat),
    .front(front)
  );

  // capture the item
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_item.command;
      id_r  <= in_item.thread_id;
    end
  end

  assign is_owner   = owner_valid_r && (owner_r == id_r);
  assign head_match = !qstat.empty && (front == id_r);
  assign id_ok      = (32'(id_r) < 32'(THREADS));
  assign midx       = TW'(id_r);

  // decide and update state
  always_comb begin
    state_nxt       = state_r;
    owner_valid_nxt = owner_valid_r;
    owner_nxt       = owner_r;
    hold_nxt        = hold_r;
    mask_nxt        = mask_r;
    out_valid_nxt   = 1'b0;
    out_item_nxt    = out_item_r;
    qcmd            = '0;
    qcmd.data       = id_r;

    case (state_r)
      frm_pkg::S_IDLE: begin
        if (accept) begin
          state_nxt = frm_pkg::S_EXEC;
        end
      end
      frm_pkg::S_EXEC: begin
        state_nxt                = frm_pkg::S_IDLE;
        out_valid_nxt            = 1'b1;
        out_item_nxt.status      = frm_pkg::STAT_REFUSED;
        out_item_nxt.wake_valid  = 1'b0;
        out_item_nxt.wake_thread = '0;
        if (cmd_r == frm_pkg::CMD_LOCK || cmd_r == frm_pkg::CMD_TRY) begin
          if (is_owner) begin
            // recursive lock by the owner
            if (&hold_r) begin
              out_item_nxt.status = frm_pkg::STAT_OVERFLOW;
            end else begin
              hold_nxt            = hold_r + COUNT_BITS'(1);
              out_item_nxt.status = frm_pkg::STAT_OK;
            end
          end else if (!owner_valid_r && (qstat.empty || head_match)) begin
            // grant a free mutex, popping the requester if it was at the front
            if (!qstat.empty) begin
              qcmd.pop = 1'b1;
              if (id_ok) begin
                mask_nxt[midx] = 1'b0;
              end
            end
            owner_valid_nxt     = 1'b1;
            owner_nxt           = id_r;
            hold_nxt            = COUNT_BITS'(1);
            out_item_nxt.status = frm_pkg::STAT_OK;
          end else if (cmd_r == frm_pkg::CMD_LOCK && id_ok) begin
            // wait, enqueuing the thread only once
            if (!mask_r[midx] && !qstat.full) begin
              mask_nxt[midx] = 1'b1;
              qcmd.push      = 1'b1;
            end
            out_item_nxt.status = frm_pkg::STAT_QUEUED;
          end
        end else if (cmd_r == frm_pkg::CMD_UNLOCK) begin
          if (is_owner) begin
            out_item_nxt.status = frm_pkg::STAT_OK;
            if (hold_r > COUNT_BITS'(1)) begin
              hold_nxt = hold_r - COUNT_BITS'(1);
            end else begin
              // release and name the front waiter
              hold_nxt        = '0;
              owner_valid_nxt = 1'b0;
              owner_nxt       = '0;
              if (!qstat.empty) begin
                out_item_nxt.wake_valid  = 1'b1;
                out_item_nxt.wake_thread = front;
              end
            end
          end else begin
            out_item_nxt.status = frm_pkg::STAT_NOT_OWNER;
          end
        end
      end
      default: begin
        state_nxt = frm_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= frm_pkg::S_IDLE;
      owner_valid_r <= 1'b0;
      owner_r       <= '0;
      hold_r        <= '0;
      mask_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      owner_valid_r <= owner_valid_nxt;
      owner_r       <= owner_nxt;
      hold_r        <= hold_nxt;
      mask_r        <= mask_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ rtl/frm_checker.sv @@
// port-level checks for the recursive mutex lock manager
`timescale 1ns / 1ps

module frm_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input frm_pkg::out_t out_item
);

  // reset leaves the block idle with no result
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("block not idle after reset");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  // every busy cycle ends in exactly one result
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("busy cycle produced no result");

  // a wake is only named on an ok result, as on a release
  a_wake_release: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.wake_valid) |-> (out_item.status == frm_pkg::STAT_OK))
    else $error("wake on a result that is not a release");

  // no wake means the wake thread reads zero
  a_wake_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.wake_valid) |-> (out_item.wake_thread == '0))
    else $error("wake thread set without wake");

endmodule

bind fifo_recursive_mutex frm_checker u_frm_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_item (out_item)
);
